// ----- rtl/core/srlb_pkg.sv -----
package srlb_pkg;

   // ring geometry (slot count must be a power of two)
   localparam int SlotCount = 256;
   localparam int SlotBits  = $clog2(SlotCount);
   localparam int WordWidth = 32;
   localparam int SeqWidth  = 64;

   localparam logic [SeqWidth-1:0] SlotCountSeq = SeqWidth'(SlotCount);

   // stream word layout
   localparam int ReqDataWidth = 96;
   localparam int RspDataWidth = 224;

   // command kinds (req_tuser)
   localparam logic CmdPush = 1'b0;
   localparam logic CmdRead = 1'b1;

   // result status (rsp_tuser)
   localparam logic [1:0] StatusPush  = 2'd0;
   localparam logic [1:0] StatusEntry = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   // item in flight while the store read completes
   typedef struct packed {
      logic                cmd;
      logic                none_new;
      logic                behind;
      logic [SeqWidth-1:0] cursor;
      logic [SeqWidth-1:0] oldest;
      logic [SeqWidth-1:0] head;
   } stage_type;

endpackage

// ----- rtl/core/srlb_ram.sv -----
module srlb_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   // single port, registered read; read data holds between reads
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/seq_ring_log_buffer_unit.sv -----
// Pipeline: two register stages, stage 1 with the store read and then the output register;
//    a taken request passes through both before its result word is presented.
// Throughput: one request per cycle while rsp is not stalled; the store does one access per
//    request, at the edge that accepts it, so back-to-back pushes and reads never collide.
// Backpressure on rsp holds the output register and then the store-read stage.
// Reset (synchronous, active high) clears the head sequence and all valid flags;
//    store contents are undefined until written and are not cleared.
module seq_ring_log_buffer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srlb_pkg::ReqDataWidth-1:0]   req_tdata,  // push_word, read_cursor
   input  logic                                req_tuser,  // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srlb_pkg::RspDataWidth-1:0]   rsp_tdata,  // read_word, next_cursor,
                                                           // dropped_count, head_sequence
   output logic [1:0]                          rsp_tuser   // status
);

   localparam int SeqWidth = srlb_pkg::SeqWidth;
   localparam int SlotBits = srlb_pkg::SlotBits;

   logic                           req_accept;
   logic                           cmd;
   logic [31:0]                    push_word;
   logic [SeqWidth-1:0]            read_cursor;
   logic                           is_push;
   logic                           none_new;
   logic                           behind;

   logic [SeqWidth-1:0]            head_ff, head_in, head_step;
   logic [SeqWidth-1:0]            oldest_ff, oldest_in;

   logic [SlotBits-1:0]            ram_addr;
   logic [srlb_pkg::WordWidth-1:0] ram_rdata;

   srlb_pkg::stage_type            s1_ff, s1_in;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_move;
   logic                           out_free;

   logic                           out_valid_ff, out_valid_in;
   logic [1:0]                     out_status_ff, out_status_in;
   logic [31:0]                    out_word_ff, out_word_in;
   logic [SeqWidth-1:0]            out_next_ff, out_next_in;
   logic [SeqWidth-1:0]            out_drop_ff, out_drop_in;
   logic [SeqWidth-1:0]            out_head_ff;

   // input word unpack
   assign cmd         = req_tuser;
   assign push_word   = req_tdata[31:0];
   assign read_cursor = req_tdata[95:32];
   assign is_push     = (cmd == srlb_pkg::CmdPush);

   // handshake: stage 1 advances when the output register is free or draining
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   // cursor classification against the retained window
   assign none_new = !(read_cursor < head_ff);
   assign behind   = (read_cursor < oldest_ff);

   // store address: push at head, read at cursor or the oldest retained entry
   always_comb begin
      if (is_push) begin
         ram_addr = head_ff[SlotBits-1:0];
      end else if (behind) begin
         ram_addr = oldest_ff[SlotBits-1:0];
      end else begin
         ram_addr = read_cursor[SlotBits-1:0];
      end
   end

   srlb_ram #(
      .Width (srlb_pkg::WordWidth),
      .Depth (srlb_pkg::SlotCount)
   ) u_store (
      .clock (clock),
      .en    (req_accept),
      .we    (is_push),
      .addr  (ram_addr),
      .wdata (srlb_pkg::WordWidth'(push_word)),
      .rdata (ram_rdata)
   );

   // head sequence and oldest retained entry
   assign head_step = head_ff + 64'd1;

   always_comb begin
      head_in   = head_ff;
      oldest_in = oldest_ff;
      if (req_accept && is_push) begin
         head_in = head_step;
         if (head_step > srlb_pkg::SlotCountSeq) begin
            oldest_in = head_step - srlb_pkg::SlotCountSeq;
         end else begin
            oldest_in = '0;
         end
      end
   end

   // stage 1 capture
   always_comb begin
      s1_in.cmd      = cmd;
      s1_in.none_new = none_new;
      s1_in.behind   = behind;
      s1_in.cursor   = read_cursor;
      s1_in.oldest   = oldest_ff;
      s1_in.head     = is_push ? head_step : head_ff;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // result formation from stage 1 and the store read data
   always_comb begin
      out_status_in = srlb_pkg::StatusPush;
      out_word_in   = '0;
      out_next_in   = s1_ff.cursor;
      out_drop_in   = '0;
      if (s1_ff.cmd == srlb_pkg::CmdRead) begin
         if (s1_ff.none_new) begin
            out_status_in = srlb_pkg::StatusEmpty;
         end else begin
            out_status_in = srlb_pkg::StatusEntry;
            out_word_in   = 32'(ram_rdata);
            if (s1_ff.behind) begin
               out_next_in = s1_ff.oldest + 64'd1;
               out_drop_in = s1_ff.oldest - s1_ff.cursor;
            end else begin
               out_next_in = s1_ff.cursor + 64'd1;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         oldest_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         oldest_ff    <= oldest_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_status_ff <= out_status_in;
         out_word_ff   <= out_word_in;
         out_next_ff   <= out_next_in;
         out_drop_ff   <= out_drop_in;
         out_head_ff   <= s1_ff.head;
      end
   end

   // output word pack
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {out_head_ff, out_drop_ff, out_next_ff, out_word_ff};

`ifndef SYNTHESIS
   // a taken push advances the head by exactly one
   a_head_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_push) |=> (head_ff == $past(head_ff) + 64'd1))
      else $error("head did not advance on push");

   // head moves only on a taken push
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && is_push) |=> $stable(head_ff))
      else $error("head moved without push");

   // stalled stage 1 blocks new requests, so the store read data is not overwritten
   a_interlock: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_tready)
      else $error("request taken while stage 1 stalled");

   // only a returned entry carries a word or a drop count
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != srlb_pkg::StatusEntry))
         |-> (out_word_ff == 32'd0 && out_drop_ff == 64'd0))
      else $error("word or drop count on non-entry result");
`endif

endmodule

// ----- tb/sv/ring_log_checker.sv -----
// Watches both stream channels of the log ring, predicts each result word
// from its request and compares the two field by field.
module ring_log_checker
   import srlb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // push_word, read_cursor
   input  logic                    req_tuser,   // cmd
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,   // read_word, next_cursor,
                                                // dropped_count, head_sequence
   input  logic [1:0]              rsp_tuser,   // status
   output int                      fail_count,
   output int                      outstanding,
   output int                      entry_seen,
   output int                      empty_seen,
   output int                      drop_seen
);

   typedef struct packed {
      logic [1:0]          status;
      logic [31:0]         read_word;
      logic [SeqWidth-1:0] next_cursor;
      logic [SeqWidth-1:0] dropped_count;
      logic [SeqWidth-1:0] head_sequence;
   } ring_result_t;

   // shadow of the ring
   logic [WordWidth-1:0] slot_words [SlotCount];
   logic [SeqWidth-1:0]  head_seq;

   ring_result_t expected_q [$];
   int fails    = 0;
   int entries  = 0;
   int empties  = 0;
   int drops    = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      entry_seen  = 0;
      empty_seen  = 0;
      drop_seen   = 0;
      head_seq    = '0;
   end

   // one request applied to the shadow ring, giving the result word it causes
   function automatic ring_result_t apply_request(input logic cmd,
                                                  input logic [31:0] word,
                                                  input logic [SeqWidth-1:0] cursor);
      ring_result_t        res;
      logic [SeqWidth-1:0] oldest;
      res = '0;
      if (cmd == CmdPush) begin
         slot_words[head_seq[SlotBits-1:0]] = word[WordWidth-1:0];
         head_seq        = head_seq + SeqWidth'(1);
         res.status      = StatusPush;
         res.next_cursor = cursor;
      end else if (cursor >= head_seq) begin
         res.status      = StatusEmpty;
         res.next_cursor = cursor;
      end else begin
         oldest = (head_seq > SlotCountSeq) ? head_seq - SlotCountSeq : '0;
         // reader fell behind: jump to the oldest entry still held
         if (cursor < oldest) begin
            res.dropped_count = oldest - cursor;
            cursor            = oldest;
         end
         res.status      = StatusEntry;
         res.read_word   = 32'(slot_words[cursor[SlotBits-1:0]]);
         res.next_cursor = cursor + SeqWidth'(1);
      end
      res.head_sequence = head_seq;
      return res;
   endfunction

   function automatic bit field_differs(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h actual %0h", name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      ring_result_t want;
      bit           bad;
      if (reset) begin
         head_seq = '0;
         expected_q.delete();
      end else begin
         // result side
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser == StatusEntry) entries++;
            if (rsp_tuser == StatusEmpty) empties++;
            if (rsp_tuser == StatusEntry && rsp_tdata[159:96] != '0) drops++;
            if (expected_q.size() == 0) begin
               $error("result word with no request pending: status %0d", rsp_tuser);
               fails++;
            end else begin
               want = expected_q.pop_front();
               bad  = field_differs("status", 64'(want.status), 64'(rsp_tuser));
               bad |= field_differs("read_word", 64'(want.read_word), 64'(rsp_tdata[31:0]));
               bad |= field_differs("next_cursor", want.next_cursor, rsp_tdata[95:32]);
               bad |= field_differs("dropped_count", want.dropped_count, rsp_tdata[159:96]);
               bad |= field_differs("head_sequence", want.head_sequence, rsp_tdata[223:160]);
               if (bad) fails++;
            end
         end
         // request side
         if (req_tvalid && req_tready)
            expected_q.push_back(apply_request(req_tuser, req_tdata[31:0],
                                               req_tdata[95:32]));
      end
      fail_count  <= fails;
      outstanding <= expected_q.size();
      entry_seen  <= entries;
      empty_seen  <= empties;
      drop_seen   <= drops;
   end

endmodule

// ----- tb/sv/testbench.sv -----
// Stimulus and verdict for the log ring; checking lives in ring_log_checker.
module testbench;
   import srlb_pkg::*;

   localparam int RandomItems = 1850;
   localparam int CycleLimit  = 400000;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    req_tuser  = CmdPush;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [1:0]              rsp_tuser;

   int fail_count;
   int outstanding;
   int entry_seen;
   int empty_seen;
   int drop_seen;

   logic [SeqWidth-1:0] head_sent = '0;   // pushes accepted so far
   int reads_sent  = 0;
   int cycle_count = 0;
   int sink_mode   = 0;
   int sink_left   = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   seq_ring_log_buffer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ring_log_checker monitor (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .entry_seen  (entry_seen),
      .empty_seen  (empty_seen),
      .drop_seen   (drop_seen)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("seq_ring_log_buffer_unit verification failed");
         $finish;
      end
   end

   // receiver backpressure: modes of random length, from never stalling to mostly stalled
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= $urandom_range(0, 3);
         sink_left <= $urandom_range(10, 120);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // present one word and hold it until taken
   task automatic issue_word(input logic cmd, input logic [31:0] word,
                             input logic [SeqWidth-1:0] cursor);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {cursor, word};
      do @(posedge clock); while (!req_tready);
      if (cmd == CmdPush) head_sent++;
      else reads_sent++;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // cursors clustered around the live window, plus wild values
   function automatic logic [SeqWidth-1:0] pick_cursor();
      case ($urandom_range(0, 11))
         0, 1: return head_sent - SeqWidth'(1);
         2:    return head_sent - SeqWidth'($urandom_range(1, 300));
         3:    return head_sent - SlotCountSeq;
         4:    return head_sent - SlotCountSeq - SeqWidth'($urandom_range(1, 4));
         5:    return head_sent - SlotCountSeq + SeqWidth'($urandom_range(1, 4));
         6:    return SeqWidth'($urandom_range(0, 64));
         7:    return head_sent;
         8:    return head_sent + SeqWidth'($urandom_range(1, 5));
         9:    return {$urandom, $urandom};
         10:   return '0;
         default: return '1 - SeqWidth'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      int burst;
      int gap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ring, word extremes, cursor at and past head
      issue_word(CmdRead, 32'h1234_5678, '0);
      issue_word(CmdRead, 32'h0, '1);
      issue_word(CmdPush, 32'h0000_0000, '1);
      issue_word(CmdPush, 32'hffff_ffff, '0);
      issue_word(CmdPush, 32'ha5a5_a5a5, 64'h5555_5555_5555_5555);
      issue_word(CmdRead, 32'hffff_ffff, 64'd0);
      issue_word(CmdRead, 32'h0, 64'd1);
      issue_word(CmdRead, 32'h0, 64'd2);
      issue_word(CmdRead, 32'h0, 64'd3);
      issue_word(CmdRead, 32'h0, 64'd4);
      issue_word(CmdRead, 32'h0, 64'h8000_0000_0000_0000);
      issue_word(CmdPush, 32'h5a5a_5a5a, 64'haaaa_aaaa_aaaa_aaaa);
      issue_word(CmdRead, 32'h0, 64'd3);
      issue_word(CmdRead, 32'h0, 64'h7fff_ffff_ffff_ffff);
      issue_word(CmdRead, 32'h0, 64'd3);

      // random: bursts with gaps, pushes enough to wrap the ring several times
      n = 0;
      while (n < RandomItems) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                             : $urandom_range(1, 16);
         for (int k = 0; k < burst && n < RandomItems; k++) begin
            if ($urandom_range(0, 99) < 55)
               issue_word(CmdPush, pick_word(), {$urandom, $urandom});
            else
               issue_word(CmdRead, pick_word(), pick_cursor());
            n++;
            // hold off halfway until the pipeline is empty
            if (n == RandomItems / 2) drain_results();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);

      $display("run: %0d pushes and %0d reads issued", head_sent, reads_sent);
      $display("reads: %0d returned a word (%0d after overwrite), %0d found nothing new",
               entry_seen, drop_seen, empty_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("seq_ring_log_buffer_unit verification clean");
      end else begin
         $display("seq_ring_log_buffer_unit verification failed");
      end
      $finish;
   end

endmodule
